>>> rtl/rnta_pkg.sv
`timescale 1ns / 1ps
// Shared types, widths and constants for the radix number to ASCII block.
// No dependencies; every other file of the block but rnta_ram imports this package.
package rnta_pkg;

    localparam int VALUE_W   = 32;
    localparam int BASE_W    = 5;
    localparam int COUNT_W   = 7;
    localparam int CHAR_W    = 8;
    localparam int DIGIT_W   = 4;
    localparam int BIT_IDX_W = $clog2(VALUE_W);
    localparam int PAD_LIMIT = 10;
    localparam int COUNT_SAT = 64;
    localparam int BASE_MIN  = 2;
    localparam int BASE_MAX  = 16;
    localparam int DEC_TEN   = 10;

    localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_A    = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_F    = 8'h46;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXTRACT,
        S_DIV,
        S_READ,
        S_SHOW
    } t_state;

    typedef enum logic [1:0] {
        P_BIN,
        P_ZERO,
        P_DIGIT
    } t_path;

    typedef struct packed {
        logic                done;
        logic [VALUE_W-1:0]  quotient;
        logic [BASE_W-1:0]   remainder;
    } t_div_res;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] dw;
        dw = CHAR_W'(d);
        if (dw < CHAR_W'(DEC_TEN)) begin
            return CHAR_ZERO + dw;
        end
        return CHAR_A + (dw - CHAR_W'(DEC_TEN));
    endfunction

endpackage

>>> rtl/rnta_in_if.sv
`timescale 1ns / 1ps
// Input channel: value, radix and digit count with valid/ready.
// Depends on rnta_pkg for field widths.
interface rnta_in_if;
    import rnta_pkg::*;

    logic                valid;
    logic                ready;
    logic [VALUE_W-1:0]  value;
    logic [BASE_W-1:0]   base;
    logic [COUNT_W-1:0]  digit_count;

    modport source (output valid, output value, output base, output digit_count,
                    input ready);
    modport sink   (input valid, input value, input base, input digit_count,
                    output ready);
endinterface

>>> rtl/rnta_out_if.sv
`timescale 1ns / 1ps
// Output channel: one ASCII character and a last flag per word, valid/ready.
// Depends on rnta_pkg for field widths.
interface rnta_out_if;
    import rnta_pkg::*;

    logic               valid;
    logic               ready;
    logic [CHAR_W-1:0]  ascii_char;
    logic               last;

    modport source (output valid, output ascii_char, output last, input ready);
    modport sink   (input valid, input ascii_char, input last, output ready);
endinterface

>>> rtl/rnta_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rnta_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> rtl/rnta_div.sv
`timescale 1ns / 1ps
// Shared restoring divider: one quotient bit per cycle.
// Depends on rnta_pkg for widths and the result struct.
module rnta_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [rnta_pkg::VALUE_W-1:0]  i_dividend,
    input  logic [rnta_pkg::BASE_W-1:0]   i_divisor,
    output rnta_pkg::t_div_res            o_res
);
    import rnta_pkg::*;

    logic                  r_busy;
    logic                  r_done;
    logic [BIT_IDX_W-1:0]  r_cnt;
    logic [VALUE_W-1:0]    r_quo;
    logic [BASE_W-1:0]     r_rem;
    logic [BASE_W-1:0]     r_den;

    logic [BASE_W:0]       trial;
    logic [BASE_W:0]       diff;
    logic                  ge;
    logic [BASE_W-1:0]     n_rem;

    always_comb begin
        trial = {r_rem, r_quo[VALUE_W-1]};
        ge    = trial >= {1'b0, r_den};
        diff  = trial - {1'b0, r_den};
        n_rem = ge ? diff[BASE_W-1:0] : trial[BASE_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_quo  <= i_dividend;
                r_rem  <= '0;
                r_den  <= i_divisor;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_quo <= {r_quo[VALUE_W-2:0], ge};
                r_cnt <= r_cnt + BIT_IDX_W'(1);
                if (r_cnt == {BIT_IDX_W{1'b1}}) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_res.done      = r_done;
    assign o_res.quotient  = r_quo;
    assign o_res.remainder = r_rem;
endmodule

>>> rtl/radix_number_to_ascii.sv
`timescale 1ns / 1ps
// Radix number to ASCII: one word in, its digit characters out, last flagged.
// Radix 2 and zero values: accepted from idle, then each character is read and shown.
// Other radixes: one division in the shared divider per digit, one store write per padding
// digit, then each character is read and shown; at most 21 digits (radix 3).
// One word at a time; input ready only when idle. Synchronous active-low reset
// returns the sequencer to idle; the digit store is not cleared.
module radix_number_to_ascii #(
    parameter int MAX_DIGITS = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rnta_in_if.sink    i_in,
    rnta_out_if.source o_out
);
    import rnta_pkg::*;

    localparam int AW = $clog2(MAX_DIGITS);
    localparam int FW = $clog2(MAX_DIGITS + 1);

    t_state              r_state, n_state;
    t_path               r_path, n_path;
    logic [VALUE_W-1:0]  r_value, n_value;
    logic [BASE_W-1:0]   r_base, n_base;
    logic [COUNT_W-1:0]  r_count, n_count;
    logic [FW-1:0]       r_found, n_found;
    logic [COUNT_W-1:0]  r_i, n_i;
    logic [COUNT_W-1:0]  r_idx, n_idx;

    logic [BASE_W-1:0]   sat_base;
    logic [COUNT_W-1:0]  sat_count;
    t_path               acc_path;
    logic [COUNT_W-1:0]  acc_len;
    logic                in_acc;
    logic                ext_end;

    logic                div_start;
    t_div_res            div_res;
    logic                ram_we;
    logic [DIGIT_W-1:0]  ram_wdata;
    logic [DIGIT_W-1:0]  ram_rdata;
    logic [COUNT_W-1:0]  pos;
    logic                bin_bit;

    rnta_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_value),
        .i_divisor  (r_base),
        .o_res      (div_res)
    );

    rnta_ram #(
        .WIDTH (DIGIT_W),
        .DEPTH (MAX_DIGITS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_found[AW-1:0]),
        .i_wdata (ram_wdata),
        .i_raddr (pos[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    // Decode of the incoming word and the extraction stop condition
    always_comb begin
        in_acc = i_in.valid && (r_state == S_IDLE);
        if (i_in.base < BASE_W'(BASE_MIN)) begin
            sat_base = BASE_W'(BASE_MIN);
        end else if (i_in.base > BASE_W'(BASE_MAX)) begin
            sat_base = BASE_W'(BASE_MAX);
        end else begin
            sat_base = i_in.base;
        end
        sat_count = (i_in.digit_count > COUNT_W'(COUNT_SAT)) ?
                    COUNT_W'(COUNT_SAT) : i_in.digit_count;
        if (sat_base == BASE_W'(BASE_MIN)) begin
            acc_path = P_BIN;
            acc_len  = sat_count;
        end else if (i_in.value == '0) begin
            acc_path = P_ZERO;
            acc_len  = (sat_count < COUNT_W'(PAD_LIMIT)) ? sat_count : COUNT_W'(PAD_LIMIT);
        end else begin
            acc_path = P_DIGIT;
            acc_len  = '0;
        end
        ext_end = (r_i >= r_count) || (r_found >= FW'(MAX_DIGITS)) ||
                  ((r_value == '0) && (r_count > COUNT_W'(PAD_LIMIT)));
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (acc_path == P_DIGIT) begin
                        n_state = S_EXTRACT;
                    end else if (acc_len != '0) begin
                        n_state = S_READ;
                    end
                end
            end
            S_EXTRACT: begin
                if (ext_end) begin
                    n_state = (r_found == '0) ? S_IDLE : S_READ;
                end else if (r_value != '0) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (div_res.done) begin
                    n_state = S_EXTRACT;
                end
            end
            S_READ: begin
                n_state = S_SHOW;
            end
            S_SHOW: begin
                if (o_out.ready) begin
                    n_state = (r_idx == COUNT_W'(1)) ? S_IDLE : S_READ;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_path    = r_path;
        n_value   = r_value;
        n_base    = r_base;
        n_count   = r_count;
        n_found   = r_found;
        n_i       = r_i;
        n_idx     = r_idx;
        div_start = 1'b0;
        ram_we    = 1'b0;
        ram_wdata = '0;
        i_in.ready = (r_state == S_IDLE);
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_path  = acc_path;
                    n_value = i_in.value;
                    n_base  = sat_base;
                    n_count = sat_count;
                    n_idx   = acc_len;
                    n_found = '0;
                    n_i     = '0;
                end
            end
            S_EXTRACT: begin
                if (ext_end) begin
                    n_idx = COUNT_W'(r_found);
                end else if (r_value != '0) begin
                    div_start = 1'b1;
                end else begin
                    ram_we  = 1'b1;
                    n_found = r_found + FW'(1);
                    n_i     = r_i + COUNT_W'(1);
                end
            end
            S_DIV: begin
                if (div_res.done) begin
                    ram_we    = 1'b1;
                    ram_wdata = div_res.remainder[DIGIT_W-1:0];
                    n_value   = div_res.quotient;
                    n_found   = r_found + FW'(1);
                    n_i       = r_i + COUNT_W'(1);
                end
            end
            S_SHOW: begin
                if (o_out.ready) begin
                    n_idx = r_idx - COUNT_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    // Character of the word on show
    always_comb begin
        pos     = r_idx - COUNT_W'(1);
        bin_bit = (pos < COUNT_W'(VALUE_W)) ? r_value[pos[BIT_IDX_W-1:0]] : 1'b0;
        case (r_path)
            P_BIN:   o_out.ascii_char = CHAR_ZERO + CHAR_W'(bin_bit);
            P_DIGIT: o_out.ascii_char = digit_char(ram_rdata);
            default: o_out.ascii_char = CHAR_ZERO;
        endcase
        o_out.valid = (r_state == S_SHOW);
        o_out.last  = (r_idx == COUNT_W'(1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_path  <= P_BIN;
            r_value <= '0;
            r_found <= '0;
            r_i     <= '0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_path  <= n_path;
            r_value <= n_value;
            r_found <= n_found;
            r_i     <= n_i;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_base  <= n_base;
        r_count <= n_count;
    end
endmodule

>>> rtl/rnta_checker.sv
`timescale 1ns / 1ps
// Port-level checks for radix_number_to_ascii, attached by bind.
// Depends on rnta_pkg for character constants and widths.
module rnta_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         i_in_ready,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input logic [rnta_pkg::CHAR_W-1:0]  i_out_char,
    input logic                         i_out_last
);
    import rnta_pkg::*;

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in_ready && i_out_valid))
        else $error("input ready while a character is on show");

    a_quiet_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_out_valid)
        else $error("character shown straight after a word was taken");

    a_idle_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ready && i_out_last) |=> !i_out_valid)
        else $error("character shown after last");

    a_char_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> ((i_out_char >= CHAR_ZERO && i_out_char <= CHAR_NINE) ||
                         (i_out_char >= CHAR_A && i_out_char <= CHAR_F)))
        else $error("character outside digit set");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_char) && $stable(i_out_last)))
        else $error("stalled output word changed");
endmodule

bind radix_number_to_ascii rnta_checker u_rnta_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_char  (o_out.ascii_char),
    .i_out_last  (o_out.last)
);

>>> tb/tb_radix_number_to_ascii.sv
`timescale 1ns / 1ps
// Testbench for radix_number_to_ascii: drives numbers in and checks each ASCII digit word out.
// Depends on rnta_pkg, rnta_in_if, rnta_out_if and the block itself.
module tb_radix_number_to_ascii;
    import rnta_pkg::*;

    localparam int STORE_DEPTH    = 32;
    localparam int MAX_REPORTS    = 10;
    localparam int RANDOM_WORDS   = 86;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int TAIL_CYCLES    = 50;

    class ascii_scoreboard;
        typedef struct packed {
            logic [CHAR_W-1:0] ch;
            logic              last;
        } t_char_word;

        t_char_word  pending_chars[$];
        int unsigned errors = 0;

        function void flag(string what);
            errors++;
            if (errors <= MAX_REPORTS) begin
                $display("%s", what);
            end
        endfunction

        function void push_char(logic [CHAR_W-1:0] ch, logic last);
            t_char_word w;
            w.ch   = ch;
            w.last = last;
            pending_chars.push_back(w);
        endfunction

        function void note_number(logic [VALUE_W-1:0] value, logic [BASE_W-1:0] base,
                                  logic [COUNT_W-1:0] count);
            int unsigned       radix;
            int unsigned       want;
            int unsigned       found;
            int unsigned       zeros;
            logic [VALUE_W-1:0] rest;
            logic [DIGIT_W-1:0] digits [STORE_DEPTH];
            logic              bitv;
            logic [CHAR_W-1:0] ch;
            radix = base;
            if (radix < BASE_MIN) radix = BASE_MIN;
            if (radix > BASE_MAX) radix = BASE_MAX;
            want = (count > COUNT_SAT) ? COUNT_SAT : count;
            if (radix == 2) begin
                for (int unsigned i = want; i != 0; i--) begin
                    bitv = (i - 1 < VALUE_W) ? value[i-1] : 1'b0;
                    push_char(CHAR_ZERO + CHAR_W'(bitv), i == 1);
                end
            end else if (value == '0) begin
                zeros = (want < PAD_LIMIT) ? want : PAD_LIMIT;
                for (int unsigned i = 0; i < zeros; i++) begin
                    push_char(CHAR_ZERO, i + 1 == zeros);
                end
            end else begin
                found = 0;
                rest  = value;
                for (int unsigned i = 0; i < want && found < STORE_DEPTH; i++) begin
                    if (rest != '0) begin
                        digits[found] = DIGIT_W'(rest % radix);
                        rest          = rest / radix;
                    end else if (want > PAD_LIMIT) begin
                        break;
                    end else begin
                        digits[found] = '0;
                    end
                    found++;
                end
                for (int unsigned i = found; i != 0; i--) begin
                    if (digits[i-1] < DEC_TEN) begin
                        ch = CHAR_ZERO + CHAR_W'(digits[i-1]);
                    end else begin
                        ch = CHAR_A + CHAR_W'(digits[i-1]) - CHAR_W'(DEC_TEN);
                    end
                    push_char(ch, i == 1);
                end
            end
        endfunction

        function void check_char(logic [CHAR_W-1:0] ch, logic last);
            t_char_word w;
            if (pending_chars.size() == 0) begin
                flag($sformatf("unexpected word: char %h last %b", ch, last));
                return;
            end
            w = pending_chars.pop_front();
            if (w.ch !== ch || w.last !== last) begin
                flag($sformatf("mismatch: expected char %h last %b, got char %h last %b",
                               w.ch, w.last, ch, last));
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    rnta_in_if  num_ch ();
    rnta_out_if char_ch ();

    ascii_scoreboard sb = new;

    int unsigned idle_cycles;
    logic [7:0]  stall_pattern;
    logic [5:0]  stall_tick;

    radix_number_to_ascii DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (num_ch),
        .o_out   (char_ch)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            if (num_ch.valid && num_ch.ready) begin
                sb.note_number(num_ch.value, num_ch.base, num_ch.digit_count);
            end
            if (char_ch.valid && char_ch.ready) begin
                sb.check_char(char_ch.ascii_char, char_ch.last);
            end
            if ((num_ch.valid && num_ch.ready) || (char_ch.valid && char_ch.ready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // re-roll the stall pattern each time the tick counter wraps; keep one ready slot so it never locks up
    always @(posedge i_clk) begin
        if (stall_tick == 0) begin
            case ($urandom_range(0, 3))
                0: stall_pattern <= 8'hFF;
                1: stall_pattern <= 8'h01;
                default: stall_pattern <= 8'($urandom()) | 8'h01;
            endcase
        end
        stall_tick    <= stall_tick + 1'b1;
        char_ch.ready <= stall_pattern[stall_tick[2:0]];
    end

    task automatic offer_number(input logic [VALUE_W-1:0] value,
                                input logic [BASE_W-1:0] base,
                                input logic [COUNT_W-1:0] count);
        num_ch.valid       <= 1'b1;
        num_ch.value       <= value;
        num_ch.base        <= base;
        num_ch.digit_count <= count;
        do @(posedge i_clk); while (!num_ch.ready);
    endtask

    task automatic offer_random_number();
        logic [VALUE_W-1:0] value;
        logic [BASE_W-1:0]  base;
        logic [COUNT_W-1:0] count;
        case ($urandom_range(0, 9))
            0: value = '0;
            1: value = VALUE_W'($urandom_range(1, 999));
            2: value = $urandom_range(0, 1) ? '1 : {1'b1, 31'($urandom())};
            default: value = $urandom();
        endcase
        case ($urandom_range(0, 19))
            0, 1, 2: base = BASE_W'(BASE_MIN);
            3:       base = BASE_W'($urandom_range(0, 1));
            4, 5:    base = BASE_W'($urandom_range(17, 31));
            default: base = BASE_W'($urandom_range(BASE_MIN, BASE_MAX));
        endcase
        case ($urandom_range(0, 9))
            6, 7:    count = COUNT_W'($urandom_range(11, 40));
            8:       count = COUNT_W'($urandom_range(41, COUNT_SAT));
            9:       count = COUNT_W'($urandom_range(0, 127));
            default: count = COUNT_W'($urandom_range(0, 12));
        endcase
        offer_number(value, base, count);
    endtask

    task automatic drain_results();
        num_ch.valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending_chars.size() != 0);
    endtask

    initial begin
        while (idle_cycles < WATCHDOG_LIMIT) @(posedge i_clk);
        $display("tb_radix_number_to_ascii NOT OK");
        $finish;
    end

    initial begin
        int unsigned sent;
        int unsigned burst;
        int unsigned gap;
        i_clk              = 1'b0;
        i_rst_n            = 1'b0;
        idle_cycles        = 0;
        stall_tick         = '0;
        stall_pattern      = 8'hFF;
        char_ch.ready      = 1'b0;
        num_ch.valid       = 1'b0;
        num_ch.value       = '0;
        num_ch.base        = '0;
        num_ch.digit_count = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        offer_number(32'h0000_0005, 5'd2, 7'd0);
        offer_number(32'h0000_0005, 5'd2, 7'd1);
        offer_number(32'hFFFF_FFFF, 5'd2, 7'd32);
        offer_number(32'hA5A5_A5A5, 5'd2, 7'd64);
        offer_number(32'h8000_0001, 5'd2, 7'd127);
        offer_number(32'h0000_00C3, 5'd0, 7'd8);
        offer_number(32'h0000_003C, 5'd1, 7'd8);
        offer_number(32'h0000_0000, 5'd10, 7'd5);
        offer_number(32'h0000_0000, 5'd10, 7'd0);
        offer_number(32'h0000_0000, 5'd10, 7'd64);
        offer_number(32'h0000_0000, 5'd31, 7'd127);
        offer_number(32'd12345, 5'd10, 7'd8);
        offer_number(32'd12345, 5'd10, 7'd3);
        offer_number(32'd12345, 5'd10, 7'd11);
        offer_number(32'hFFFF_FFFF, 5'd10, 7'd10);
        offer_number(32'hDEAD_BEEF, 5'd16, 7'd64);
        offer_number(32'hFEDC_BA98, 5'd16, 7'd8);
        offer_number(32'hCAFE_F00D, 5'd31, 7'd20);
        offer_number(32'h7654_3210, 5'd17, 7'd9);
        offer_number(32'hFFFF_FFFF, 5'd3, 7'd64);
        offer_number(32'h1234_5678, 5'd10, 7'd0);
        offer_number(32'h0000_0001, 5'd7, 7'd10);
        offer_number(32'h0000_0001, 5'd7, 7'd11);
        offer_number(32'hFFFF_FFFF, 5'd15, 7'd40);
        drain_results();

        sent = 0;
        while (sent < RANDOM_WORDS) begin
            burst = $urandom_range(1, 8);
            for (int k = 0; k < burst && sent < RANDOM_WORDS; k++) begin
                offer_random_number();
                sent++;
            end
            if (sent >= RANDOM_WORDS / 2 && sent - burst < RANDOM_WORDS / 2) begin
                drain_results();
            end else begin
                gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                if (gap != 0) begin
                    num_ch.valid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending_chars.size() == 0) begin
            $display("tb_radix_number_to_ascii OK");
        end else begin
            $display("tb_radix_number_to_ascii NOT OK");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/rnta_pkg.sv
rtl/rnta_in_if.sv
rtl/rnta_out_if.sv
rtl/rnta_ram.sv
rtl/rnta_div.sv
rtl/radix_number_to_ascii.sv
rtl/rnta_checker.sv
tb/tb_radix_number_to_ascii.sv
